// File: rtl/sscp_pkg.sv
package sscp_pkg;

  // Number formats
  localparam int COORD_W         = 32;
  localparam int COORD_FRAC_BITS = 16;
  localparam int PARAM_FRAC_BITS = 16;
  localparam int LIMIT_W         = 32;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd4295;

  // Internal widths
  localparam int DIFF_W    = COORD_W + 1;            // coordinate differences
  localparam int PROD_W    = 2 * DIFF_W;             // one term of a dot product
  localparam int DOT_W     = PROD_W + 2;             // dot products a..e
  localparam int HALF_W    = DOT_W / 2;              // split point of a dot product
  localparam int PART_W    = 2 * (HALF_W + 1);       // partial product
  localparam int WIDE_W    = 2 * DOT_W + 2;          // det, sn, tn
  localparam int REM_W     = WIDE_W + 1;             // divider remainder
  localparam int QUOT_W    = PARAM_FRAC_BITS + 1;    // quotient incl. 1.0
  localparam int MUL_W     = QUOT_W + 1 + DIFF_W;    // parameter times difference
  localparam int CMP_W     = DIFF_W + PARAM_FRAC_BITS + 4;  // distance component
  localparam int SQ_LO_W   = (CMP_W + 1) / 2;
  localparam int SQ_OP_W   = SQ_LO_W + 1;
  localparam int SQ_PART_W = 2 * SQ_OP_W;
  localparam int SCORE_W   = 2 * CMP_W + 2;
  localparam int N_CAND    = 4;

  // Port widths
  localparam int PARAM_W     = 17;
  localparam int CASE_W      = 3;
  localparam int IN_DATA_W   = 12 * COORD_W;
  localparam int OUT_DATA_W  = ((2 * PARAM_W + 7) / 8) * 8;

  // Pipeline stages
  localparam int ST_GEO   = 0;
  localparam int ST_PROD  = 1;
  localparam int ST_DOT   = 2;
  localparam int ST_PART  = 3;
  localparam int ST_WIDE  = 4;
  localparam int ST_NUM   = 5;
  localparam int ST_CASE  = 6;
  localparam int ST_SETUP = 7;
  localparam int ST_DIV0  = 8;
  localparam int ST_QUOT  = ST_DIV0 + PARAM_FRAC_BITS;
  localparam int ST_MUL   = ST_QUOT + 1;
  localparam int ST_COMP  = ST_MUL + 1;
  localparam int ST_SQP   = ST_COMP + 1;
  localparam int ST_SQ    = ST_SQP + 1;
  localparam int ST_SCORE = ST_SQ + 1;
  localparam int ST_PICK  = ST_SCORE + 1;
  localparam int ST_OUT   = ST_PICK + 1;
  localparam int N_STAGES = ST_OUT + 1;

  // Case codes
  localparam logic [CASE_W-1:0] CASE_PARALLEL = 3'd0;
  localparam logic [CASE_W-1:0] CASE_Q_DEGEN  = 3'd1;
  localparam logic [CASE_W-1:0] CASE_P_DEGEN  = 3'd2;
  localparam logic [CASE_W-1:0] CASE_INTERIOR = 3'd3;
  localparam logic [CASE_W-1:0] CASE_ENDPOINT = 3'd4;

  // Divider lane codes
  localparam logic [1:0] DIV_RUN  = 2'd0;
  localparam logic [1:0] DIV_ZERO = 2'd1;
  localparam logic [1:0] DIV_ONE  = 2'd2;

  typedef logic signed [HALF_W:0] hop_t;

  typedef struct packed {
    logic [2:0][DIFF_W-1:0] d1;
    logic [2:0][DIFF_W-1:0] d2;
    logic [2:0][DIFF_W-1:0] r;
  } geo_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] a;
    logic signed [DOT_W-1:0] b;
    logic signed [DOT_W-1:0] c;
    logic signed [DOT_W-1:0] d;
    logic signed [DOT_W-1:0] e;
  } dots_t;

  typedef struct packed {
    logic signed [PART_W-1:0] hh;
    logic signed [PART_W-1:0] hl;
    logic signed [PART_W-1:0] lh;
    logic signed [PART_W-1:0] ll;
  } part_t;

  typedef struct packed {
    logic [1:0]                 code;
    logic [REM_W-1:0]           rem;
    logic [REM_W-1:0]           den;
    logic [PARAM_FRAC_BITS-1:0] q;
  } lane_t;

  function automatic hop_t half_hi(input logic [DOT_W-1:0] x);
    return hop_t'($signed(x[DOT_W-1:HALF_W]));
  endfunction

  function automatic hop_t half_lo(input logic [DOT_W-1:0] x);
    return hop_t'({1'b0, x[HALF_W-1:0]});
  endfunction

  // Four partial products of a wide signed multiply
  function automatic part_t mul_parts(input logic [DOT_W-1:0] x,
                                      input logic [DOT_W-1:0] y);
    part_t p;
    p.hh = half_hi(x) * half_hi(y);
    p.hl = half_hi(x) * half_lo(y);
    p.lh = half_lo(x) * half_hi(y);
    p.ll = half_lo(x) * half_lo(y);
    return p;
  endfunction

  function automatic logic signed [WIDE_W-1:0] join_parts(input part_t p);
    logic signed [WIDE_W-1:0] hh;
    logic signed [WIDE_W-1:0] mid;
    logic signed [WIDE_W-1:0] ll;
    hh  = WIDE_W'(p.hh);
    mid = WIDE_W'(p.hl) + WIDE_W'(p.lh);
    ll  = WIDE_W'(p.ll);
    return (hh <<< (2 * HALF_W)) + (mid <<< HALF_W) + ll;
  endfunction

  // Load a divider lane and settle the clamped and degenerate outcomes
  function automatic lane_t lane_setup(input logic signed [WIDE_W-1:0] num,
                                       input logic signed [WIDE_W-1:0] den);
    lane_t y;
    y.rem = REM_W'(num);
    y.den = REM_W'(den);
    y.q   = '0;
    if (den <= 0)        y.code = DIV_ZERO;
    else if (num <= 0)   y.code = DIV_ZERO;
    else if (num >= den) y.code = DIV_ONE;
    else                 y.code = DIV_RUN;
    return y;
  endfunction

  // One restoring division step
  function automatic lane_t div_step(input lane_t x);
    lane_t            y;
    logic [REM_W-1:0] r2;
    y  = x;
    r2 = x.rem << 1;
    if (r2 >= x.den) begin
      y.rem = r2 - x.den;
      y.q   = {x.q[PARAM_FRAC_BITS-2:0], 1'b1};
    end else begin
      y.rem = r2;
      y.q   = {x.q[PARAM_FRAC_BITS-2:0], 1'b0};
    end
    return y;
  endfunction

  function automatic logic [QUOT_W-1:0] quot_value(input lane_t x);
    logic [QUOT_W-1:0] v;
    case (x.code)
      DIV_RUN: v = {1'b0, x.q};
      DIV_ONE: v = QUOT_W'(1) << PARAM_FRAC_BITS;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/segment_segment_closest_params.sv
// Closest-point parameters between two 3D segments, fully pipelined.
// The restoring divider produces one quotient bit per stage.
// Throughput: one segment pair per cycle; each stage stalls only when full
// and the stage after it cannot take its contents.
// Reset (rst, synchronous): clears all stage valid bits, limit back to 4295.
module segment_segment_closest_params
  import sscp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [LIMIT_W-1:0]    cfg_wr_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // p_start_x, p_start_y, p_start_z, p_end_x, p_end_y, p_end_z,
  // q_start_x, q_start_y, q_start_z, q_end_x, q_end_y, q_end_z
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // s_param, t_param, zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  // case_taken
  output logic [CASE_W-1:0]     m_tuser
);

  logic [LIMIT_W-1:0]  near_zero_limit;
  logic [N_STAGES-1:0] vld;
  logic [N_STAGES-1:0] en;

  geo_t  geo    [ST_GEO:ST_COMP-1];
  geo_t  geo_next;
  logic signed [PROD_W-1:0] pa [3];
  logic signed [PROD_W-1:0] pb [3];
  logic signed [PROD_W-1:0] pc [3];
  logic signed [PROD_W-1:0] pd [3];
  logic signed [PROD_W-1:0] pe [3];
  dots_t dt     [ST_DOT:ST_SETUP-1];
  dots_t dt_next;
  logic [1:0] lo_flg [ST_PART:ST_CASE-1];
  logic [1:0] lo_flg_next;
  part_t pt_ac, pt_bb, pt_eb, pt_dc, pt_ea, pt_db;
  logic signed [WIDE_W-1:0] w_ac, w_bb, w_eb, w_dc, w_ea, w_db;
  logic signed [WIDE_W-1:0] det5, sn5, tn5;
  logic signed [WIDE_W-1:0] det6, sn6, tn6;
  logic [CASE_W-1:0] kase [ST_CASE:ST_OUT-1];
  logic [CASE_W-1:0] kase_next;
  lane_t dv [0:PARAM_FRAC_BITS][N_CAND];
  lane_t dv_next [N_CAND];
  logic [QUOT_W-1:0] qv [ST_QUOT:ST_OUT-1][N_CAND];
  logic [QUOT_W-1:0] cs [N_CAND];
  logic [QUOT_W-1:0] ct [N_CAND];
  logic signed [MUL_W-1:0] sd [N_CAND][3];
  logic signed [MUL_W-1:0] td [N_CAND][3];
  logic signed [CMP_W-1:0] comp [N_CAND][3];
  logic signed [SQ_PART_W-1:0] sq_hh [N_CAND][3];
  logic signed [SQ_PART_W-1:0] sq_hl [N_CAND][3];
  logic signed [SQ_PART_W-1:0] sq_ll [N_CAND][3];
  logic signed [SCORE_W-1:0] sq [N_CAND][3];
  logic [SCORE_W-1:0] score [N_CAND];
  logic [1:0] pick;
  logic [1:0] pick_next;
  logic [PARAM_W-1:0] s_out, t_out, s_sel, t_sel;
  logic [CASE_W-1:0]  case_out;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      near_zero_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      near_zero_limit <= cfg_wr_data;
    end
  end

  // Stage enables: a stage advances when it is empty or its successor moves
  always_comb begin
    en[N_STAGES-1] = ~vld[N_STAGES-1] | m_tready;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = vld[N_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_tvalid;
      for (int k = 1; k < N_STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 0: direction vectors and offset
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      geo_next.d1[i] = DIFF_W'($signed(s_tdata[(3 + i) * COORD_W +: COORD_W]))
                     - DIFF_W'($signed(s_tdata[i * COORD_W +: COORD_W]));
      geo_next.d2[i] = DIFF_W'($signed(s_tdata[(9 + i) * COORD_W +: COORD_W]))
                     - DIFF_W'($signed(s_tdata[(6 + i) * COORD_W +: COORD_W]));
      geo_next.r[i]  = DIFF_W'($signed(s_tdata[i * COORD_W +: COORD_W]))
                     - DIFF_W'($signed(s_tdata[(6 + i) * COORD_W +: COORD_W]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_GEO]) geo[ST_GEO] <= geo_next;
    for (int k = ST_GEO + 1; k < ST_COMP; k++) begin
      if (en[k]) geo[k] <= geo[k-1];
    end
  end

  // Stage 1: dot product terms
  always_ff @(posedge clk) begin
    if (en[ST_PROD]) begin
      for (int i = 0; i < 3; i++) begin
        pa[i] <= $signed(geo[ST_GEO].d1[i]) * $signed(geo[ST_GEO].d1[i]);
        pb[i] <= $signed(geo[ST_GEO].d1[i]) * $signed(geo[ST_GEO].d2[i]);
        pc[i] <= $signed(geo[ST_GEO].d2[i]) * $signed(geo[ST_GEO].d2[i]);
        pd[i] <= $signed(geo[ST_GEO].d1[i]) * $signed(geo[ST_GEO].r[i]);
        pe[i] <= $signed(geo[ST_GEO].d2[i]) * $signed(geo[ST_GEO].r[i]);
      end
    end
  end

  // Stage 2: sum the terms
  always_comb begin
    dt_next.a = DOT_W'(pa[0]) + DOT_W'(pa[1]) + DOT_W'(pa[2]);
    dt_next.b = DOT_W'(pb[0]) + DOT_W'(pb[1]) + DOT_W'(pb[2]);
    dt_next.c = DOT_W'(pc[0]) + DOT_W'(pc[1]) + DOT_W'(pc[2]);
    dt_next.d = DOT_W'(pd[0]) + DOT_W'(pd[1]) + DOT_W'(pd[2]);
    dt_next.e = DOT_W'(pe[0]) + DOT_W'(pe[1]) + DOT_W'(pe[2]);
  end

  always_ff @(posedge clk) begin
    if (en[ST_DOT]) dt[ST_DOT] <= dt_next;
    for (int k = ST_DOT + 1; k < ST_SETUP; k++) begin
      if (en[k]) dt[k] <= dt[k-1];
    end
  end

  // Stage 3: partial products and small dot product checks
  always_comb begin
    logic [DOT_W+31:0] lim_dot;
    lim_dot = (DOT_W + 32)'(near_zero_limit) << (2 * COORD_FRAC_BITS);
    // bit 1: c degenerate, bit 0: a degenerate
    lo_flg_next[1] = $signed({dt[ST_DOT].c, 32'd0}) < $signed({1'b0, lim_dot});
    lo_flg_next[0] = $signed({dt[ST_DOT].a, 32'd0}) < $signed({1'b0, lim_dot});
  end

  always_ff @(posedge clk) begin
    if (en[ST_PART]) begin
      pt_ac <= mul_parts(dt[ST_DOT].a, dt[ST_DOT].c);
      pt_bb <= mul_parts(dt[ST_DOT].b, dt[ST_DOT].b);
      pt_eb <= mul_parts(dt[ST_DOT].e, dt[ST_DOT].b);
      pt_dc <= mul_parts(dt[ST_DOT].d, dt[ST_DOT].c);
      pt_ea <= mul_parts(dt[ST_DOT].e, dt[ST_DOT].a);
      pt_db <= mul_parts(dt[ST_DOT].d, dt[ST_DOT].b);
      lo_flg[ST_PART] <= lo_flg_next;
    end
    for (int k = ST_PART + 1; k < ST_CASE; k++) begin
      if (en[k]) lo_flg[k] <= lo_flg[k-1];
    end
  end

  // Stage 4: assemble the wide products
  always_ff @(posedge clk) begin
    if (en[ST_WIDE]) begin
      w_ac <= join_parts(pt_ac);
      w_bb <= join_parts(pt_bb);
      w_eb <= join_parts(pt_eb);
      w_dc <= join_parts(pt_dc);
      w_ea <= join_parts(pt_ea);
      w_db <= join_parts(pt_db);
    end
  end

  // Stage 5: determinant and interior numerators
  always_ff @(posedge clk) begin
    if (en[ST_NUM]) begin
      det5 <= w_ac - w_bb;
      sn5  <= w_eb - w_dc;
      tn5  <= w_ea - w_db;
    end
  end

  // Stage 6: pick the case
  always_comb begin
    logic [WIDE_W+31:0] lim_det;
    logic               det_lo;
    logic               inner;
    lim_det = (WIDE_W + 32)'(near_zero_limit) << (4 * COORD_FRAC_BITS);
    det_lo  = $signed({det5, 32'd0}) < $signed({1'b0, lim_det});
    inner   = (tn5 > 0) && (tn5 < det5) && (sn5 > 0) && (sn5 < det5);
    if (det_lo)                     kase_next = CASE_PARALLEL;
    else if (lo_flg[ST_CASE-1][1])  kase_next = CASE_Q_DEGEN;
    else if (lo_flg[ST_CASE-1][0])  kase_next = CASE_P_DEGEN;
    else if (inner)                 kase_next = CASE_INTERIOR;
    else                            kase_next = CASE_ENDPOINT;
  end

  always_ff @(posedge clk) begin
    if (en[ST_CASE]) begin
      det6 <= det5;
      sn6  <= sn5;
      tn6  <= tn5;
      kase[ST_CASE] <= kase_next;
    end
    for (int k = ST_CASE + 1; k < ST_OUT; k++) begin
      if (en[k]) kase[k] <= kase[k-1];
    end
  end

  // Stage 7: load the four divider lanes
  always_comb begin
    dots_t d;
    d = dt[ST_SETUP-1];
    if (kase[ST_CASE] == CASE_INTERIOR) begin
      dv_next[0] = lane_setup(sn6, det6);
      dv_next[2] = lane_setup(tn6, det6);
    end else begin
      dv_next[0] = lane_setup(WIDE_W'(d.e) + WIDE_W'(d.b), WIDE_W'(d.c));
      dv_next[2] = lane_setup(WIDE_W'(d.b) - WIDE_W'(d.d), WIDE_W'(d.a));
    end
    dv_next[1] = lane_setup(WIDE_W'(d.e), WIDE_W'(d.c));
    dv_next[3] = lane_setup(-WIDE_W'(d.d), WIDE_W'(d.a));
  end

  // Divider: one quotient bit per stage in every lane
  always_ff @(posedge clk) begin
    if (en[ST_SETUP]) begin
      for (int l = 0; l < N_CAND; l++) dv[0][l] <= dv_next[l];
    end
    for (int j = 1; j <= PARAM_FRAC_BITS; j++) begin
      if (en[ST_DIV0 + j - 1]) begin
        for (int l = 0; l < N_CAND; l++) dv[j][l] <= div_step(dv[j-1][l]);
      end
    end
  end

  // Clamped quotients
  always_ff @(posedge clk) begin
    if (en[ST_QUOT]) begin
      for (int l = 0; l < N_CAND; l++) qv[ST_QUOT][l] <= quot_value(dv[PARAM_FRAC_BITS][l]);
    end
    for (int k = ST_QUOT + 1; k < ST_OUT; k++) begin
      if (en[k]) qv[k] <= qv[k-1];
    end
  end

  // Endpoint candidates: (1,t0) (0,t1) (s2,1) (s3,0)
  always_comb begin
    cs[0] = QUOT_W'(1) << PARAM_FRAC_BITS;
    ct[0] = qv[ST_QUOT][0];
    cs[1] = '0;
    ct[1] = qv[ST_QUOT][1];
    cs[2] = qv[ST_QUOT][2];
    ct[2] = QUOT_W'(1) << PARAM_FRAC_BITS;
    cs[3] = qv[ST_QUOT][3];
    ct[3] = '0;
  end

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      for (int k = 0; k < N_CAND; k++) begin
        for (int i = 0; i < 3; i++) begin
          sd[k][i] <= $signed({1'b0, cs[k]}) * $signed(geo[ST_MUL-1].d1[i]);
          td[k][i] <= $signed({1'b0, ct[k]}) * $signed(geo[ST_MUL-1].d2[i]);
        end
      end
    end
  end

  // Distance components r + s*d1 - t*d2
  always_ff @(posedge clk) begin
    if (en[ST_COMP]) begin
      for (int k = 0; k < N_CAND; k++) begin
        for (int i = 0; i < 3; i++) begin
          comp[k][i] <= (CMP_W'($signed(geo[ST_COMP-1].r[i])) <<< PARAM_FRAC_BITS)
                      + CMP_W'(sd[k][i]) - CMP_W'(td[k][i]);
        end
      end
    end
  end

  // Square partials: high half signed, low half unsigned
  always_ff @(posedge clk) begin
    if (en[ST_SQP]) begin
      for (int k = 0; k < N_CAND; k++) begin
        for (int i = 0; i < 3; i++) begin
          sq_hh[k][i] <= $signed(SQ_OP_W'($signed(comp[k][i][CMP_W-1:SQ_LO_W])))
                       * $signed(SQ_OP_W'($signed(comp[k][i][CMP_W-1:SQ_LO_W])));
          sq_hl[k][i] <= $signed(SQ_OP_W'($signed(comp[k][i][CMP_W-1:SQ_LO_W])))
                       * $signed({1'b0, comp[k][i][SQ_LO_W-1:0]});
          sq_ll[k][i] <= $signed({1'b0, comp[k][i][SQ_LO_W-1:0]})
                       * $signed({1'b0, comp[k][i][SQ_LO_W-1:0]});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_SQ]) begin
      for (int k = 0; k < N_CAND; k++) begin
        for (int i = 0; i < 3; i++) begin
          sq[k][i] <= (SCORE_W'(sq_hh[k][i]) <<< (2 * SQ_LO_W))
                    + (SCORE_W'(sq_hl[k][i]) <<< (SQ_LO_W + 1))
                    + SCORE_W'(sq_ll[k][i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_SCORE]) begin
      for (int k = 0; k < N_CAND; k++) begin
        score[k] <= sq[k][0] + sq[k][1] + sq[k][2];
      end
    end
  end

  // First minimum: beats every earlier score, no later one is lower (ties go to the earlier)
  always_comb begin
    logic [N_CAND-1:0] win;
    for (int k = 0; k < N_CAND; k++) begin
      win[k] = 1'b1;
      for (int j = 0; j < N_CAND; j++) begin
        if (j < k && !(score[k] < score[j])) win[k] = 1'b0;
        if (j > k && (score[j] < score[k]))  win[k] = 1'b0;
      end
    end
    if (win[0])      pick_next = 2'd0;
    else if (win[1]) pick_next = 2'd1;
    else if (win[2]) pick_next = 2'd2;
    else             pick_next = 2'd3;
  end

  always_ff @(posedge clk) begin
    if (en[ST_PICK]) pick <= pick_next;
  end

  // Output select
  always_comb begin
    logic [QUOT_W-1:0] q0, q1, q2, q3, one;
    q0  = qv[ST_OUT-1][0];
    q1  = qv[ST_OUT-1][1];
    q2  = qv[ST_OUT-1][2];
    q3  = qv[ST_OUT-1][3];
    one = QUOT_W'(1) << PARAM_FRAC_BITS;
    case (kase[ST_OUT-1])
      CASE_PARALLEL, CASE_P_DEGEN: begin
        s_sel = '0;
        t_sel = PARAM_W'(q1);
      end
      CASE_Q_DEGEN: begin
        s_sel = PARAM_W'(q3);
        t_sel = '0;
      end
      CASE_INTERIOR: begin
        s_sel = PARAM_W'(q0);
        t_sel = PARAM_W'(q2);
      end
      default: begin
        case (pick)
          2'd0: begin s_sel = PARAM_W'(one); t_sel = PARAM_W'(q0);  end
          2'd1: begin s_sel = '0;            t_sel = PARAM_W'(q1);  end
          2'd2: begin s_sel = PARAM_W'(q2);  t_sel = PARAM_W'(one); end
          default: begin s_sel = PARAM_W'(q3); t_sel = '0; end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      s_out    <= s_sel;
      t_out    <= t_sel;
      case_out <= kase[ST_OUT-1];
    end
  end

  assign m_tdata = OUT_DATA_W'({t_out, s_out});
  assign m_tuser = case_out;

endmodule
